// ===== sv/bpc_pkg.sv =====
// Shared constants and helpers for the barometric pressure compensation block.
// No dependencies; imported by the top level.
package bpc_pkg;

   localparam int unsigned WordW = 32;
   localparam int unsigned CsrAddrW = 2;
   localparam int unsigned CsrDataW = 64;

   // register indexes on the configuration port
   localparam logic [CsrAddrW-1:0] CSR_AC1_AC4 = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_AC5_B2 = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_MC_MD = 2'd2;
   localparam logic [CsrAddrW-1:0] CSR_OSS = 2'd3;

   localparam logic [1:0] OSS_RESET = 2'd3;

   // compensation constants
   localparam logic [WordW-1:0] C_B6_OFFSET = 32'd4000;
   localparam logic [WordW-1:0] C_X3_BIAS = 32'd32768;
   localparam logic [WordW-1:0] C_B7_SCALE = 32'd50000;
   localparam logic [WordW-1:0] C_P_SQ = 32'd3038;
   localparam logic [WordW-1:0] C_P_LIN = 32'hFFFF_E343; // -7357
   localparam logic [WordW-1:0] C_P_OFS = 32'd3791;

   typedef logic [WordW-1:0] word_type;

   // arithmetic shift right of a 32-bit pattern
   function automatic word_type asr32(input word_type x, input int unsigned n);
      asr32 = word_type'($signed(x) >>> n);
   endfunction

   // sign-extend a 16-bit field
   function automatic word_type sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

endpackage

// ===== sv/bpc_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on nothing; carries a sideband payload alongside each operand pair.
module bpc_div #(
   parameter int unsigned W = 32,
   parameter int unsigned S = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [W-1:0] in_num,
   input  logic [W-1:0] in_den,
   input  logic [S-1:0] in_side,
   output logic         out_valid,
   output logic [W-1:0] out_quo,
   output logic [S-1:0] out_side
);

   logic         valid_ff [W];
   logic [W-1:0] rem_ff   [W];
   logic [W-1:0] quo_ff   [W];
   logic [W-1:0] den_ff   [W];
   logic [S-1:0] side_ff  [W];

   genvar k;
   generate
      for (k = 0; k < W; k++) begin : g_stage
         logic         valid_in;
         logic [W-1:0] rem_in;
         logic [W-1:0] quo_in;
         logic [W-1:0] den_in;
         logic [S-1:0] side_in;
         logic [W:0]   trial;
         logic [W:0]   diff;

         if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = '0;
            assign quo_in   = in_num;
            assign den_in   = in_den;
            assign side_in  = in_side;
         end else begin : g_next
            assign valid_in = valid_ff[k-1];
            assign rem_in   = rem_ff[k-1];
            assign quo_in   = quo_ff[k-1];
            assign den_in   = den_ff[k-1];
            assign side_in  = side_ff[k-1];
         end

         // shift in the next dividend bit and try the subtraction
         assign trial = {rem_in, quo_in[W-1]};
         assign diff  = trial - {1'b0, den_in};

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= valid_in;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               if (!diff[W]) begin
                  rem_ff[k] <= diff[W-1:0];
                  quo_ff[k] <= {quo_in[W-2:0], 1'b1};
               end else begin
                  rem_ff[k] <= trial[W-1:0];
                  quo_ff[k] <= {quo_in[W-2:0], 1'b0};
               end
               den_ff[k]  <= den_in;
               side_ff[k] <= side_in;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[W-1];
   assign out_quo   = quo_ff[W-1];
   assign out_side  = side_ff[W-1];

endmodule

// ===== sv/barometric_pressure_compensation.sv =====
// Top level of the barometric pressure compensation pipeline.
// Depends on bpc_pkg and bpc_div.
//
// Usage:
//   req_* channel: one beat carries a raw temperature word and a raw 24-bit
//   pressure reading. rsp_* channel: one beat carries the compensated
//   temperature (0.1 degC) and pressure (Pa) in rsp_tdata, and the divide
//   fault flag in rsp_tuser; on a fault both values are zero.
//   csr_* port: write calibration words and oversampling while idle.
// A beat passes two setup stages, a 32-stage unsigned temperature
// divider with signs handled outside it, nine pressure stages, a 32-stage
// unsigned pressure divider and four finishing stages. Throughput is one
// beat per cycle while the receiver does not stall; every stage is a
// register and each divider produces one quotient bit per stage.
// Reset empties the pipeline and loads the register defaults (calibration
// zero, oversampling 3). When the receiver stalls, the whole pipeline
// holds: req_tready follows the output register being free or taken, so no
// beat is lost or repeated.
module barometric_pressure_compensation (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,  // raw_temperature[15:0], raw_pressure[39:16]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,  // temperature[31:0], pressure[63:32]
   output logic                          rsp_tuser,  // divide_fault
   input  logic                          csr_we,
   input  logic [bpc_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [bpc_pkg::CsrDataW-1:0]  csr_wdata
);
   import bpc_pkg::*;

   // configuration registers
   logic [63:0] ac1_ac4_ff;
   logic [63:0] ac5_b2_ff;
   logic [31:0] mc_md_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac4_ff <= '0;
         ac5_b2_ff  <= '0;
         mc_md_ff   <= '0;
         oss_ff     <= OSS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_AC1_AC4: ac1_ac4_ff <= csr_wdata;
            CSR_AC5_B2:  ac5_b2_ff  <= csr_wdata;
            CSR_MC_MD:   mc_md_ff   <= csr_wdata[31:0];
            CSR_OSS:     oss_ff     <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // calibration fields
   word_type ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(ac1_ac4_ff[63:48]);
   assign ac2 = sx16(ac1_ac4_ff[47:32]);
   assign ac3 = sx16(ac1_ac4_ff[31:16]);
   assign ac4 = {16'd0, ac1_ac4_ff[15:0]};
   assign ac5 = {16'd0, ac5_b2_ff[63:48]};
   assign ac6 = {16'd0, ac5_b2_ff[47:32]};
   assign b1  = sx16(ac5_b2_ff[31:16]);
   assign b2  = sx16(ac5_b2_ff[15:0]);
   assign mc  = sx16(mc_md_ff[31:16]);
   assign md  = sx16(mc_md_ff[15:0]);

   // global advance: output register free or being taken
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 1: temperature product, raw pressure alignment
   logic        v1_ff;
   word_type    m1_ff;
   logic [23:0] up1_ff;
   word_type    d1;
   assign d1 = {16'd0, req_tdata[15:0]} - ac6;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= d1 * ac5;
         up1_ff <= req_tdata[39:16] >> (4'd8 - {2'b00, oss_ff});
      end
   end

   // stage 2: temperature divisor, sign and magnitudes for the divider
   logic        v2_ff;
   word_type    x1_2_ff, num2_ff, den2_ff;
   logic        neg2_ff, ft2_ff;
   logic [23:0] up2_ff;
   word_type    x1_t, den_t, num_t;
   assign x1_t  = asr32(m1_ff, 15);
   assign den_t = x1_t + md;
   assign num_t = {mc[20:0], 11'd0};

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x1_2_ff <= x1_t;
         num2_ff <= num_t[31] ? (~num_t + 32'd1) : num_t;
         den2_ff <= den_t[31] ? (~den_t + 32'd1) : den_t;
         neg2_ff <= num_t[31] ^ den_t[31];
         ft2_ff  <= (den_t == '0);
         up2_ff  <= up1_ff;
      end
   end

   // temperature divider
   localparam int unsigned TSideW = 24 + 32 + 2;
   logic              vt;
   word_type          qt;
   logic [TSideW-1:0] st;

   bpc_div #(.W(32), .S(TSideW)) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_num    (num2_ff),
      .in_den    (den2_ff),
      .in_side   ({up2_ff, x1_2_ff, neg2_ff, ft2_ff}),
      .out_valid (vt),
      .out_quo   (qt),
      .out_side  (st)
   );

   // stage 3: b5
   logic        v3_ff, f3_ff;
   word_type    b5_3_ff;
   logic [23:0] up3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= vt;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b5_3_ff <= st[33:2] + (st[1] ? (~qt + 32'd1) : qt);
         f3_ff   <= st[0];
         up3_ff  <= st[57:34];
      end
   end

   // stage 4: temperature result and b6
   logic        v4_ff, f4_ff;
   word_type    t4_ff, b6_4_ff;
   logic [23:0] up4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         t4_ff   <= asr32(b5_3_ff + 32'd8, 4);
         b6_4_ff <= b5_3_ff - C_B6_OFFSET;
         f4_ff   <= f3_ff;
         up4_ff  <= up3_ff;
      end
   end

   // stage 5: products of b6
   logic        v5_ff, f5_ff;
   word_type    t5_ff, msq5_ff, mac2_5_ff, mac3_5_ff;
   logic [23:0] up5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         msq5_ff   <= b6_4_ff * b6_4_ff;
         mac2_5_ff <= ac2 * b6_4_ff;
         mac3_5_ff <= ac3 * b6_4_ff;
         t5_ff     <= t4_ff;
         f5_ff     <= f4_ff;
         up5_ff    <= up4_ff;
      end
   end

   // stage 6: scale products
   logic        v6_ff, f6_ff;
   word_type    t6_ff, sq6_ff, x2a6_ff, x1c6_ff;
   logic [23:0] up6_ff;

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (en) v6_ff <= v5_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sq6_ff  <= asr32(msq5_ff, 12);
         x2a6_ff <= asr32(mac2_5_ff, 11);
         x1c6_ff <= asr32(mac3_5_ff, 13);
         t6_ff   <= t5_ff;
         f6_ff   <= f5_ff;
         up6_ff  <= up5_ff;
      end
   end

   // stage 7: products of the square term
   logic        v7_ff, f7_ff;
   word_type    t7_ff, mb2_7_ff, mb1_7_ff, x2a7_ff, x1c7_ff;
   logic [23:0] up7_ff;

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (en) v7_ff <= v6_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         mb2_7_ff <= b2 * sq6_ff;
         mb1_7_ff <= b1 * sq6_ff;
         x2a7_ff  <= x2a6_ff;
         x1c7_ff  <= x1c6_ff;
         t7_ff    <= t6_ff;
         f7_ff    <= f6_ff;
         up7_ff   <= up6_ff;
      end
   end

   // stage 8: partial sums for b3 and b4
   logic        v8_ff, f8_ff;
   word_type    t8_ff, x3_8_ff, xs8_ff;
   logic [23:0] up8_ff;

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (en) v8_ff <= v7_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x3_8_ff <= asr32(mb2_7_ff, 11) + x2a7_ff;
         xs8_ff  <= x1c7_ff + asr32(mb1_7_ff, 16);
         t8_ff   <= t7_ff;
         f8_ff   <= f7_ff;
         up8_ff  <= up7_ff;
      end
   end

   // stage 9: b3 and the b4 multiplicand
   logic        v9_ff, f9_ff;
   word_type    t9_ff, b3_9_ff, xp9_ff;
   logic [23:0] up9_ff;
   word_type    b3_base;
   assign b3_base = ({ac1[29:0], 2'b00} + x3_8_ff) << oss_ff;

   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (en) v9_ff <= v8_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b3_9_ff <= asr32(b3_base + 32'd2, 2);
         xp9_ff  <= asr32(xs8_ff + 32'd2, 2) + C_X3_BIAS;
         t9_ff   <= t8_ff;
         f9_ff   <= f8_ff;
         up9_ff  <= up8_ff;
      end
   end

   // stage 10: b4 and the pressure difference
   logic     v10_ff, f10_ff;
   word_type t10_ff, b4_10_ff, dp10_ff, m_b4;
   assign m_b4 = ac4 * xp9_ff;

   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0;
      else if (en) v10_ff <= v9_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b4_10_ff <= m_b4 >> 15;
         dp10_ff  <= {8'd0, up9_ff} - b3_9_ff;
         t10_ff   <= t9_ff;
         f10_ff   <= f9_ff;
      end
   end

   // stage 11: b7 and pressure divisor check
   logic     v11_ff, f11_ff;
   word_type t11_ff, b7_11_ff, b4_11_ff;

   always_ff @(posedge clock) begin
      if (reset) v11_ff <= 1'b0;
      else if (en) v11_ff <= v10_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b7_11_ff <= dp10_ff * (C_B7_SCALE >> oss_ff);
         b4_11_ff <= b4_10_ff;
         f11_ff   <= f10_ff || (b4_10_ff == '0);
         t11_ff   <= t10_ff;
      end
   end

   // pressure divider: doubled dividend unless b7 has its top bit set
   localparam int unsigned PSideW = 32 + 2;
   logic              vp;
   word_type          qp;
   logic [PSideW-1:0] sp;

   bpc_div #(.W(32), .S(PSideW)) u_div_p (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v11_ff),
      .in_num    (b7_11_ff[31] ? b7_11_ff : {b7_11_ff[30:0], 1'b0}),
      .in_den    (b4_11_ff),
      .in_side   ({t11_ff, b7_11_ff[31], f11_ff}),
      .out_valid (vp),
      .out_quo   (qp),
      .out_side  (sp)
   );

   // stage 12: raw pressure
   logic     v12_ff, f12_ff;
   word_type t12_ff, p12_ff;

   always_ff @(posedge clock) begin
      if (reset) v12_ff <= 1'b0;
      else if (en) v12_ff <= vp;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p12_ff <= sp[1] ? {qp[30:0], 1'b0} : qp;
         t12_ff <= sp[33:2];
         f12_ff <= sp[0];
      end
   end

   // stage 13: correction products
   logic     v13_ff, f13_ff;
   word_type t13_ff, p13_ff, m13_ff, ml13_ff, ps12;
   assign ps12 = asr32(p12_ff, 8);

   always_ff @(posedge clock) begin
      if (reset) v13_ff <= 1'b0;
      else if (en) v13_ff <= v12_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m13_ff  <= ps12 * ps12;
         ml13_ff <= C_P_LIN * p12_ff;
         p13_ff  <= p12_ff;
         t13_ff  <= t12_ff;
         f13_ff  <= f12_ff;
      end
   end

   // stage 14: scale the square term and the linear term
   logic     v14_ff, f14_ff;
   word_type t14_ff, p14_ff, x1_14_ff, x2_14_ff;

   always_ff @(posedge clock) begin
      if (reset) v14_ff <= 1'b0;
      else if (en) v14_ff <= v13_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x1_14_ff <= m13_ff * C_P_SQ;
         x2_14_ff <= asr32(ml13_ff, 16);
         p14_ff   <= p13_ff;
         t14_ff   <= t13_ff;
         f14_ff   <= f13_ff;
      end
   end

   // stage 15: output register, zero both results on a fault
   logic     out_v_ff, out_f_ff;
   word_type out_t_ff, out_p_ff, corr;
   assign corr = asr32(asr32(x1_14_ff, 16) + x2_14_ff + C_P_OFS, 4);

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= v14_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         out_t_ff <= f14_ff ? '0 : t14_ff;
         out_p_ff <= f14_ff ? '0 : (p14_ff + corr);
         out_f_ff <= f14_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_p_ff, out_t_ff};
   assign rsp_tuser  = out_f_ff;

endmodule

// ===== sv/bpc_checker.sv =====
// Port-level checks for barometric_pressure_compensation, with its bind.
// Depends only on the top level's ports.
module bpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   // output is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled beat holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

   // a faulted beat carries zero results
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("fault beat with nonzero data");

   // input side stalls only while the output beat waits
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready out of step with output register");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
